>>> src/msi_pkg.sv
// ----------------------------------------------------------------------------
// msi_pkg
// Shared constants, command codes and control types for the MSI translation
// LRU cache.
// ----------------------------------------------------------------------------
package msi_pkg;

  localparam int CACHE_ENTRIES = 64;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_INVAL  = 2'd2;

  // controller to datapath strobes
  typedef struct packed {
    logic load;   // capture the accepted item
    logic match;  // compare key, pick entry, read stored id
    logic exec;   // update state and load the result register
  } dp_cmd_t;

endpackage

>>> src/msi_if.sv
// ----------------------------------------------------------------------------
// msi_in_if / msi_out_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface msi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [47:0] doorbell;
  logic [15:0] dev_id;
  logic [15:0] evt_id;
  logic [15:0] intid;
  logic        direct;
  modport source (output valid, cmd, doorbell, dev_id, evt_id, intid, direct,
                  input ready);
  modport sink (input valid, cmd, doorbell, dev_id, evt_id, intid, direct,
                output ready);
endinterface

interface msi_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] hit_intid;
  logic        evicted_valid;
  logic [15:0] evicted_intid;
  logic [6:0]  cleared_count;
  modport source (output valid, hit, hit_intid, evicted_valid, evicted_intid,
                  cleared_count, input ready);
  modport sink (input valid, hit, hit_intid, evicted_valid, evicted_intid,
                cleared_count, output ready);
endinterface

>>> src/msi_translation_lru_cache_core.sv
// ----------------------------------------------------------------------------
// msi_translation_lru_cache_core
// Fully associative LRU cache of MSI translations (doorbell, device, event
// to interrupt id).
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request items (lookup, insert, invalidate all) on valid/ready.
//   out_ch : one result item per request on valid/ready.
// The request is captured at the accepting edge; the result then follows
// the match step, the parallel key compare over all entry lanes and the
// stored-id memory read, and the execute step, which updates ranks and
// entries and loads the result register. A new item is accepted in the
// cycle after the previous one retires: the sequencer runs capture, match
// and execute without overlap, so no item is taken before the last one is
// through. The result register holds a finished item while the next one is
// accepted and matched; if the receiver stalls, the second item waits in
// the execute step until the register drains.
// Reset clears all valid bits and the fill count and restores the ranks to
// entry order at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module msi_translation_lru_cache_core (
  input logic clk,
  input logic rst_n,
  msi_in_if.sink    in_ch,
  msi_out_if.source out_ch
);
  import msi_pkg::*;

  dp_cmd_t dp_cmd;

  msi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd)
  );

  msi_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .in_cmd            (in_ch.cmd),
    .in_doorbell       (in_ch.doorbell),
    .in_dev_id         (in_ch.dev_id),
    .in_evt_id         (in_ch.evt_id),
    .in_intid          (in_ch.intid),
    .in_direct         (in_ch.direct),
    .out_hit           (out_ch.hit),
    .out_hit_intid     (out_ch.hit_intid),
    .out_evicted_valid (out_ch.evicted_valid),
    .out_evicted_intid (out_ch.evicted_intid),
    .out_cleared_count (out_ch.cleared_count)
  );

  // execute never directly follows the accept of an item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !dp_cmd.exec)
    else $error("execute directly after accept");

  // no new item while one is in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.match |-> !in_ch.ready)
    else $error("accept during match");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.hit) |-> !out_ch.evicted_valid)
    else $error("hit with eviction");

  // cleared count never exceeds the capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cleared_count <= 7'(CACHE_ENTRIES)))
    else $error("cleared count too large");

endmodule

>>> src/msi_ctrl.sv
// ----------------------------------------------------------------------------
// msi_ctrl
// Sequencer: accept, match, execute; owns the result valid flag.
// ----------------------------------------------------------------------------
module msi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output msi_pkg::dp_cmd_t cmd
);
  import msi_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and strobes
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // result register must be free before the item retires
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/msi_dp.sv
// ----------------------------------------------------------------------------
// msi_dp
// Datapath: key lanes with parallel compare, rank registers, stored-id
// memory, valid count and result register.
// ----------------------------------------------------------------------------
module msi_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  msi_pkg::dp_cmd_t cmd,
  input  logic [1:0]       in_cmd,
  input  logic [47:0]      in_doorbell,
  input  logic [15:0]      in_dev_id,
  input  logic [15:0]      in_evt_id,
  input  logic [15:0]      in_intid,
  input  logic             in_direct,
  output logic             out_hit,
  output logic [15:0]      out_hit_intid,
  output logic             out_evicted_valid,
  output logic [15:0]      out_evicted_intid,
  output logic [6:0]       out_cleared_count
);
  import msi_pkg::*;

  // captured request
  logic [1:0]  req_cmd_r;
  logic [47:0] req_db_r;
  logic [15:0] req_dev_r, req_ev_r, req_id_r;
  logic        req_dir_r;

  // entry lanes
  logic [47:0]      key_db_r  [CACHE_ENTRIES];
  logic [15:0]      key_dev_r [CACHE_ENTRIES];
  logic [15:0]      key_ev_r  [CACHE_ENTRIES];
  logic [IDX_W-1:0] age_r     [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0] count_r;

  // stored interrupt ids
  logic [15:0] id_mem [CACHE_ENTRIES];
  logic [15:0] rd_r;

  // match stage results
  logic [CACHE_ENTRIES-1:0] sel_r;
  logic             hit_r, old_valid_r;
  logic [IDX_W-1:0] idx_r, rank_r;

  logic [CACHE_ENTRIES-1:0] match_c, oldest_c;
  logic             hit_c;
  logic [IDX_W-1:0] hit_idx_c, old_idx_c, hit_rank_c, addr_c;

  // parallel tag compare and LRU pick
  always_comb begin
    hit_idx_c  = '0;
    old_idx_c  = '0;
    hit_rank_c = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      match_c[i]  = valid_r[i] && (key_db_r[i] == req_db_r) &&
                    (key_dev_r[i] == req_dev_r) && (key_ev_r[i] == req_ev_r);
      oldest_c[i] = (age_r[i] == IDX_W'(CACHE_ENTRIES - 1));
      if (match_c[i]) begin
        hit_idx_c  = hit_idx_c | IDX_W'(i);
        hit_rank_c = hit_rank_c | age_r[i];
      end
      if (oldest_c[i]) old_idx_c = old_idx_c | IDX_W'(i);
    end
    hit_c  = |match_c;
    addr_c = hit_c ? hit_idx_c : old_idx_c;
  end

  // decode of the retiring item
  logic lk_hit, ins, ins_hit, ins_miss, promote, inval;
  assign lk_hit   = (req_cmd_r == CMD_LOOKUP) && hit_r;
  assign ins      = (req_cmd_r == CMD_INSERT) && !req_dir_r;
  assign ins_hit  = ins && hit_r;
  assign ins_miss = ins && !hit_r;
  assign promote  = lk_hit || ins;
  assign inval    = (req_cmd_r == CMD_INVAL);

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r <= in_cmd;
      req_db_r  <= in_doorbell;
      req_dev_r <= in_dev_id;
      req_ev_r  <= in_evt_id;
      req_id_r  <= in_intid;
      req_dir_r <= in_direct;
    end
    if (cmd.match) begin
      sel_r       <= hit_c ? match_c : oldest_c;
      hit_r       <= hit_c;
      idx_r       <= addr_c;
      rank_r      <= hit_c ? hit_rank_c : IDX_W'(CACHE_ENTRIES - 1);
      old_valid_r <= |(oldest_c & valid_r);
    end
    if (cmd.exec) begin
      out_hit           <= lk_hit || ins_hit;
      out_hit_intid     <= (lk_hit || ins_hit) ? rd_r : 16'd0;
      out_evicted_valid <= ins_miss && old_valid_r;
      out_evicted_intid <= (ins_miss && old_valid_r) ? rd_r : 16'd0;
      out_cleared_count <= inval ? 7'(count_r) : 7'd0;
      if (ins_miss) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (sel_r[i]) begin
            key_db_r[i]  <= req_db_r;
            key_dev_r[i] <= req_dev_r;
            key_ev_r[i]  <= req_ev_r;
          end
        end
      end
    end
  end

  // stored-id memory: one read in match, one write in execute
  always_ff @(posedge clk) begin
    if (cmd.match) rd_r <= id_mem[addr_c];
    if (cmd.exec && ins_miss) id_mem[idx_r] <= req_id_r;
  end

  // control state: valid bits, ranks, fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) age_r[i] <= IDX_W'(i);
    end else if (cmd.exec) begin
      if (promote) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (sel_r[i])             age_r[i] <= '0;
          else if (age_r[i] < rank_r) age_r[i] <= age_r[i] + 1'b1;
        end
      end
      if (ins_miss) begin
        valid_r <= valid_r | sel_r;
        if (!old_valid_r) count_r <= count_r + 1'b1;
      end
      if (inval) begin
        valid_r <= '0;
        count_r <= '0;
      end
    end
  end

endmodule
